// File: sv/falc_pkg.sv
// ----------------------------------------------------------------------------
// Fully associative LRU tag store: shared definitions
// Field widths of the stream beats and the configuration register indexes.
// ----------------------------------------------------------------------------
package falc_pkg;

  localparam int AddrW      = 16;
  localparam int LineW      = 4;
  localparam int CountW     = 32;
  localparam int CfgDataW   = 5;
  localparam int OutTdataW  = 136;

  typedef enum logic [0:0] {
    CFG_OFFSET_BITS  = 1'b0,
    CFG_LINES_IN_USE = 1'b1
  } cfg_idx_e;

endpackage

// File: sv/fully_associative_lru_cache_tags_core.sv
// ----------------------------------------------------------------------------
// Fully associative LRU cache tag store
// An access beat's search record walks the row of line cells, one cell a cycle,
//   then the result is registered on commit once the output register is free.
// A new beat is taken only after the last one commits; a clear skips the search.
// Reset: all lines invalid, counters zero, offset_bits 2, lines_in_use 16.
// ----------------------------------------------------------------------------
module fully_associative_lru_cache_tags_core #(
  parameter int LINES     = 16,
  parameter int ADDR_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream. tdata: address[15:0]. tuser: mode (1 = clear).
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [falc_pkg::AddrW-1:0]   s_axis_tdata,
  input  logic                         s_axis_tuser,
  // Result stream. tdata from the lowest bit up: hit, replaced,
  // victim_tag[15:0], line[3:0], block_base[15:0], hit_count[31:0],
  // miss_count[31:0], replace_count[31:0], two zero pad bits.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [falc_pkg::OutTdataW-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [falc_pkg::CfgDataW-1:0] cfg_data_i
);

  import falc_pkg::*;

  // Index width of a line, width of a stored tag, width of a line count.
  localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int TAG_W  = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam int NW     = $clog2(LINES + 1);
  localparam int CARRY_W = 3 * IDX_W + TIME_BITS + TAG_W + 3;

  // The search record, handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                 hit_f;
    logic [IDX_W-1:0]     hit_idx;
    logic                 inv_f;
    logic [IDX_W-1:0]     inv_idx;
    logic                 min_f;
    logic [IDX_W-1:0]     min_idx;
    logic [TIME_BITS-1:0] min_ts;
    logic [TAG_W-1:0]     min_tag;
  } carry_t;

  // The write-back command broadcast to every cell in the commit cycle.
  typedef struct packed {
    logic                 we;
    logic                 clr;
    logic [IDX_W-1:0]     idx;
    logic [TAG_W-1:0]     tag;
    logic [TIME_BITS-1:0] ts;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     cnt_q;
  logic                 clr_q;
  logic [TAG_W-1:0]     key_q;
  logic [TAG_W-1:0]     base_q;

  logic [3:0]           off_q;
  logic [4:0]           lines_q;

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [CountW-1:0]    hits_q, hits_d;
  logic [CountW-1:0]    miss_q, miss_d;
  logic [CountW-1:0]    repl_q, repl_d;

  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  logic [TAG_W-1:0]     addr_m, tag_in, base_in;
  logic [NW-1:0]        n_eff;
  logic [LINES-1:0]     in_use;
  logic [CARRY_W-1:0]   chain [LINES+1];
  carry_t               fin;
  upd_t                 upd;
  logic                 commit_go;

  logic [IDX_W-1:0]     sel;
  logic                 repl;
  logic [TAG_W-1:0]     victim;

  // The block takes a new beat only when no item is at work; a finished
  // result may still wait in the output register meanwhile.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A commit may only overwrite the output register once it is free.
  assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);

  // Tag and block base of the incoming address. An offset as wide as the
  // address leaves no tag bits at all.
  always_comb begin
    addr_m = s_axis_tdata[TAG_W-1:0];
    if ({2'b00, off_q} >= 6'(ADDR_BITS)) begin
      tag_in  = '0;
      base_in = '0;
    end else begin
      tag_in  = addr_m >> off_q;
      base_in = tag_in << off_q;
    end
  end

  // A line count of zero acts as one, and one above the row as the row.
  always_comb begin
    if (lines_q == 5'd0) begin
      n_eff = NW'(1);
    end else if ({4'b0000, lines_q} > 9'(LINES)) begin
      n_eff = NW'(LINES);
    end else begin
      n_eff = NW'(lines_q);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < LINES; i++) begin : g_cell
    assign in_use[i] = (NW'(i) < n_eff);

    falc_cell #(
      .IDX    (i),
      .IDX_W  (IDX_W),
      .TAG_W  (TAG_W),
      .TIME_W (TIME_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .in_use_i (in_use[i]),
      .key_i    (key_q),
      .carry_i  (chain[i]),
      .carry_o  (chain[i+1]),
      .upd_i    (upd)
    );
  end

  assign fin = carry_t'(chain[LINES]);

  // Choice of line: the hit, else the lowest free line, else the oldest.
  always_comb begin
    repl   = !fin.hit_f && !fin.inv_f;
    sel    = fin.hit_f ? fin.hit_idx : (fin.inv_f ? fin.inv_idx : fin.min_idx);
    victim = repl ? fin.min_tag : '0;
  end

  // Counter updates, write-back command and the result beat.
  always_comb begin
    time_d     = time_q;
    hits_d     = hits_q;
    miss_d     = miss_q;
    repl_d     = repl_q;
    upd        = '0;
    out_data_d = '0;
    if (clr_q) begin
      time_d  = '0;
      hits_d  = '0;
      miss_d  = '0;
      repl_d  = '0;
      upd.clr = 1'b1;
    end else begin
      time_d = (&time_q) ? time_q : time_q + 1'b1;
      if (fin.hit_f) begin
        hits_d = (&hits_q) ? hits_q : hits_q + 1'b1;
      end else begin
        miss_d = (&miss_q) ? miss_q : miss_q + 1'b1;
        if (repl) begin
          repl_d = (&repl_q) ? repl_q : repl_q + 1'b1;
        end
      end
      upd.we  = 1'b1;
      upd.idx = sel;
      upd.tag = key_q;
      upd.ts  = time_d;
      out_data_d = {2'b00, repl_d, miss_d, hits_d, AddrW'(base_q), LineW'(sel),
                    AddrW'(victim), repl, fin.hit_f};
    end
    if (!commit_go) begin
      upd.we  = 1'b0;
      upd.clr = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      clr_q       <= 1'b0;
      off_q       <= 4'd2;
      lines_q     <= 5'd16;
      time_q      <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      repl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_OFFSET_BITS:  off_q   <= cfg_data_i[3:0];
          CFG_LINES_IN_USE: lines_q <= cfg_data_i;
          default:          off_q   <= off_q;
        endcase
      end
      // A commit refills the output register in the same cycle that the
      // waiting beat leaves it.
      if (commit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            clr_q   <= s_axis_tuser;
            cnt_q   <= '0;
            state_q <= s_axis_tuser ? ST_COMMIT : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (cnt_q == IDX_W'(LINES - 1)) begin
            state_q <= ST_COMMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            time_q      <= time_d;
            hits_q      <= hits_d;
            miss_q      <= miss_d;
            repl_q      <= repl_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: the search key and the result beat.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q  <= tag_in;
      base_q <= base_in;
    end
    if (commit_go) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  // A beat never reports a hit that also evicted a line.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit and replaced set together");

  // Without an eviction the victim tag reads zero.
  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("victim tag set without eviction");

  // The search always ends in the commit cycle after the last cell.
  a_search_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && cnt_q == IDX_W'(LINES - 1)) |=> (state_q == ST_COMMIT))
    else $error("search did not hand over to commit");

  // A committed beat is always shown in the following cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go |=> m_axis_tvalid)
    else $error("committed result not presented");
`endif

endmodule

// File: sv/falc_cell.sv
// ----------------------------------------------------------------------------
// Fully associative LRU tag store: one line cell
// Holds one line and folds its state into the search record passing by.
// ----------------------------------------------------------------------------
module falc_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 4,
  parameter int TAG_W  = 16,
  parameter int TIME_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_use_i,
  input  logic [TAG_W-1:0]  key_i,
  input  logic [IDX_W+IDX_W+IDX_W+TIME_W+TAG_W+3+0-1:0] carry_i,
  output logic [IDX_W+IDX_W+IDX_W+TIME_W+TAG_W+3+0-1:0] carry_o,
  input  logic [IDX_W+TAG_W+TIME_W+2-1:0] upd_i
);

  typedef struct packed {
    logic              hit_f;
    logic [IDX_W-1:0]  hit_idx;
    logic              inv_f;
    logic [IDX_W-1:0]  inv_idx;
    logic              min_f;
    logic [IDX_W-1:0]  min_idx;
    logic [TIME_W-1:0] min_ts;
    logic [TAG_W-1:0]  min_tag;
  } carry_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] ts;
  } upd_t;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  carry_t            cin, carry_d, carry_q;
  upd_t              upd;
  logic              valid_q;
  logic [TAG_W-1:0]  tag_q;
  logic [TIME_W-1:0] ts_q;

  assign cin     = carry_t'(carry_i);
  assign upd     = upd_t'(upd_i);
  assign carry_o = carry_q;

  always_comb begin
    carry_d = cin;
    if (in_use_i) begin
      if (valid_q && (tag_q == key_i) && !cin.hit_f) begin
        carry_d.hit_f   = 1'b1;
        carry_d.hit_idx = MyIdx;
      end
      if (!valid_q && !cin.inv_f) begin
        carry_d.inv_f   = 1'b1;
        carry_d.inv_idx = MyIdx;
      end
      // Strict compare keeps the lower index on equal timestamps.
      if (valid_q && (!cin.min_f || (ts_q < cin.min_ts))) begin
        carry_d.min_f   = 1'b1;
        carry_d.min_idx = MyIdx;
        carry_d.min_ts  = ts_q;
        carry_d.min_tag = tag_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      valid_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
      if (upd.clr) begin
        valid_q <= 1'b0;
      end else if (upd.we && (upd.idx == MyIdx)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.we && !upd.clr && (upd.idx == MyIdx)) begin
      tag_q <= upd.tag;
      ts_q  <= upd.ts;
    end
  end

endmodule

// File: tb/sv/tb_fully_associative_lru_cache_tags_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the fully associative LRU cache tag store
// Streams access and clear beats into the core and keeps its own model of the
// tag store. Every result beat is checked field by field against the oldest
// predicted lookup. The configuration is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_fully_associative_lru_cache_tags_core;
  import falc_pkg::*;

  localparam int LINES          = 16;
  localparam int RESULT_LATENCY = LINES + 2;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RES_W          = 134;

  // One result beat, declared from the top field down so that hit sits in bit 0.
  typedef struct packed {
    logic [CountW-1:0] replace_count;
    logic [CountW-1:0] miss_count;
    logic [CountW-1:0] hit_count;
    logic [AddrW-1:0]  block_base;
    logic [LineW-1:0]  line;
    logic [AddrW-1:0]  victim_tag;
    logic              replaced;
    logic              hit;
  } lookup_res_t;

  typedef struct {
    logic             clear;
    logic [AddrW-1:0] addr;
  } access_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [AddrW-1:0]      s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [0:0]            cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;

  // Model of the tag store and its configuration.
  logic [3:0]        offset_bits_q;
  logic [4:0]        lines_in_use_q;
  logic              tag_valid [LINES];
  logic [AddrW-1:0]  tag_store [LINES];
  logic [31:0]       stamp     [LINES];
  logic [31:0]       access_clock;
  logic [CountW-1:0] hits_seen, misses_seen, evictions_seen;

  access_t     access_backlog [$];
  lookup_res_t lookups_due    [$];
  access_t     drv_item;
  lookup_res_t mon_pred, mon_exp, mon_got;

  int  src_idle_pct  = 0;
  int  sink_idle_pct = 0;
  int  fail_count    = 0;
  int  cycles        = 0;
  bit  in_taken      = 1'b0;

  fully_associative_lru_cache_tags_core #(
    .LINES     (LINES),
    .ADDR_BITS (AddrW),
    .TIME_BITS (32)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // address[15:0]
    .s_axis_tuser  (s_axis_tuser),   // mode (1 = clear)
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // hit, replaced, victim_tag, line, block_base, hit_count, miss_count,
    // replace_count, zero padding
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clears the whole model, as both reset and a clear beat do.
  task automatic wipe_model();
    for (int i = 0; i < LINES; i++) begin
      tag_valid[i] = 1'b0;
      tag_store[i] = '0;
      stamp[i]     = '0;
    end
    access_clock   = '0;
    hits_seen      = '0;
    misses_seen    = '0;
    evictions_seen = '0;
  endtask

  // Predicts the result of one beat and updates the model accordingly.
  task automatic cache_lookup(input logic clear, input logic [AddrW-1:0] addr,
                              output lookup_res_t res);
    int               n;
    int               sel;
    logic [AddrW-1:0] tag;
    res = '0;
    if (clear) begin
      wipe_model();
      return;
    end
    n = (lines_in_use_q == 0) ? 1 : (lines_in_use_q > LINES) ? LINES : lines_in_use_q;
    tag = addr >> offset_bits_q;
    res.block_base = tag << offset_bits_q;
    if (access_clock != '1) access_clock++;
    sel = -1;
    for (int i = 0; i < n; i++) begin
      if (sel < 0 && tag_valid[i] && tag_store[i] == tag) sel = i;
    end
    if (sel >= 0) begin
      res.hit = 1'b1;
      if (hits_seen != '1) hits_seen++;
      stamp[sel] = access_clock;
    end else begin
      if (misses_seen != '1) misses_seen++;
      for (int i = 0; i < n; i++) begin
        if (sel < 0 && !tag_valid[i]) sel = i;
      end
      if (sel < 0) begin
        // Oldest timestamp wins, the lowest index on a tie.
        sel = 0;
        for (int i = 1; i < n; i++) begin
          if (stamp[i] < stamp[sel]) sel = i;
        end
        res.replaced   = 1'b1;
        res.victim_tag = tag_store[sel];
        if (evictions_seen != '1) evictions_seen++;
      end
      tag_valid[sel] = 1'b1;
      tag_store[sel] = tag;
      stamp[sel]     = access_clock;
    end
    res.line = sel[LineW-1:0];
    res.hit_count     = hits_seen;
    res.miss_count    = misses_seen;
    res.replace_count = evictions_seen;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: a new beat is offered once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (access_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_item = access_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drv_item.clear;
          s_axis_tdata  <= drv_item.addr;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: predicts on every accepted input beat and checks every result beat.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        cache_lookup(s_axis_tuser, s_axis_tdata, mon_pred);
        lookups_due = {lookups_due, mon_pred};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (lookups_due.size() == 0) begin
          $error("result beat with no lookup outstanding");
          fail_count++;
        end else begin
          mon_exp = lookups_due.pop_front();
          mon_got = m_axis_tdata[RES_W-1:0];
          check_field("hit",           32'(mon_exp.hit),           32'(mon_got.hit));
          check_field("replaced",      32'(mon_exp.replaced),      32'(mon_got.replaced));
          check_field("victim_tag",    32'(mon_exp.victim_tag),    32'(mon_got.victim_tag));
          check_field("line",          32'(mon_exp.line),          32'(mon_got.line));
          check_field("block_base",    32'(mon_exp.block_base),    32'(mon_got.block_base));
          check_field("hit_count",     mon_exp.hit_count,          mon_got.hit_count);
          check_field("miss_count",    mon_exp.miss_count,         mon_got.miss_count);
          check_field("replace_count", mon_exp.replace_count,      mon_got.replace_count);
          check_field("padding",       '0, 32'(m_axis_tdata[OutTdataW-1:RES_W]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_access(input logic clear, input logic [AddrW-1:0] addr);
    access_t item;
    item.clear = clear;
    item.addr  = addr;
    access_backlog = {access_backlog, item};
  endtask

  // Mostly addresses from a small pool of tags, a little wider than the lines
  // in use, so that hits and LRU evictions are frequent; the rest are random
  // addresses and the odd clear.
  task automatic fill_random(input int count);
    int               n;
    int               pick;
    logic [AddrW-1:0] pool_base;
    logic [AddrW-1:0] low_mask;
    logic [AddrW-1:0] tag;
    n = (lines_in_use_q == 0) ? 1 : (lines_in_use_q > LINES) ? LINES : lines_in_use_q;
    pool_base = AddrW'($urandom);
    low_mask  = (16'd1 << offset_bits_q) - 16'd1;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        queue_access(1'b1, AddrW'($urandom));
      end else if (pick < 80) begin
        tag = pool_base + AddrW'($urandom_range(n + 2));
        queue_access(1'b0, (tag << offset_bits_q) | (AddrW'($urandom) & low_mask));
      end else begin
        queue_access(1'b0, AddrW'($urandom));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_OFFSET_BITS) offset_bits_q = value[3:0];
    else lines_in_use_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every beat has gone in and every result has come back, then
  // lets the pipeline settle before the configuration is touched.
  task automatic drain();
    while (access_backlog.size() != 0 || s_axis_tvalid || lookups_due.size() != 0)
      @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    offset_bits_q  = 4'd2;
    lines_in_use_q = 5'd16;
    wipe_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: address extremes, hits within a block, a clear
    // with a non-zero address, then a fresh miss after the clear.
    src_idle_pct  = 7;
    sink_idle_pct = 46;
    queue_access(1'b0, 16'h0000);
    queue_access(1'b0, 16'hFFFF);
    queue_access(1'b0, 16'h0003);
    queue_access(1'b0, 16'hFFFC);
    queue_access(1'b1, 16'hFFFF);
    queue_access(1'b0, 16'h1234);
    fill_random(330);
    drain();

    // Byte blocks and two lines: a refreshed line survives, the LRU one goes.
    write_reg(CFG_OFFSET_BITS, 5'd0);
    write_reg(CFG_LINES_IN_USE, 5'd2);
    queue_access(1'b1, 16'h0000);
    queue_access(1'b0, 16'h0001);
    queue_access(1'b0, 16'h0002);
    queue_access(1'b0, 16'h0001);
    queue_access(1'b0, 16'h0003);
    queue_access(1'b0, 16'h0002);
    queue_access(1'b0, 16'h0000);
    fill_random(320);
    drain();

    // Widest offset, written with the unused top bit set, over all lines.
    src_idle_pct  = 46;
    sink_idle_pct = 7;
    write_reg(CFG_OFFSET_BITS, 5'h1F);
    write_reg(CFG_LINES_IN_USE, 5'd16);
    queue_access(1'b0, 16'h7FFF);
    queue_access(1'b0, 16'h8000);
    queue_access(1'b0, 16'hFFFF);
    fill_random(320);
    drain();

    // A line count of zero behaves as one line; the upper lines keep their tags.
    write_reg(CFG_OFFSET_BITS, 5'd4);
    write_reg(CFG_LINES_IN_USE, 5'd0);
    fill_random(330);
    drain();

    // Counts above the number of lines are capped, so old tags come back in.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_reg(CFG_OFFSET_BITS, 5'd3);
    write_reg(CFG_LINES_IN_USE, 5'd31);
    fill_random(330);
    drain();

    write_reg(CFG_OFFSET_BITS, CfgDataW'($urandom_range(15)));
    write_reg(CFG_LINES_IN_USE, CfgDataW'($urandom_range(1, 16)));
    fill_random(330);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/falc_pkg.sv
sv/falc_cell.sv
sv/fully_associative_lru_cache_tags_core.sv
tb/sv/tb_fully_associative_lru_cache_tags_core.sv
